// ----- hdl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the TCP segment checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PROTO_W = 8;
    // four address halves plus the protocol byte fit in 19 bits
    localparam int unsigned PH_W    = 19;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO    = 2'd2;

    localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;

    // finished segment handed from the byte accumulator to the fold stage
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [WORD_W-1:0] len;
    } seg_t;

endpackage

`default_nettype wire

// ----- hdl/tcs_accum.sv -----
// ----------------------------------------------------------------------------
// tcs_accum
// Pairs bytes into big-endian words, keeps the running sum and byte count,
// and registers the segment sum and length when the last byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_accum (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tcs_pkg::BYTE_W-1:0]  s_data_byte,
    input  wire logic                        s_last_byte,
    input  wire logic                        seg_take,
    output logic                             seg_valid,
    output tcs_pkg::seg_t                    seg
);

    logic [tcs_pkg::SUM_W-1:0]  running_sum_reg;
    logic [tcs_pkg::WORD_W-1:0] byte_count_reg;
    logic [tcs_pkg::BYTE_W-1:0] pending_reg;
    logic                       odd_reg;
    logic                       seg_valid_reg;
    tcs_pkg::seg_t              seg_reg;

    logic                       accept;
    logic [tcs_pkg::WORD_W-1:0] word;
    logic [tcs_pkg::SUM_W-1:0]  sum_next;
    logic [tcs_pkg::WORD_W-1:0] count_next;

    // stage holds at most one finished segment
    assign s_ready = !seg_valid_reg || seg_take;
    assign accept  = s_valid && s_ready;

    // odd trailing byte goes high with a zero low byte
    assign word       = odd_reg ? {pending_reg, s_data_byte}
                                : {s_data_byte, {tcs_pkg::BYTE_W{1'b0}}};
    assign sum_next   = running_sum_reg + {{(tcs_pkg::SUM_W-tcs_pkg::WORD_W){1'b0}}, word};
    assign count_next = byte_count_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
            byte_count_reg  <= '0;
            odd_reg         <= 1'b0;
            seg_valid_reg   <= 1'b0;
        end else begin
            if (seg_take) begin
                seg_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_last_byte) begin
                    running_sum_reg <= '0;
                    byte_count_reg  <= '0;
                    odd_reg         <= 1'b0;
                    seg_valid_reg   <= 1'b1;
                end else begin
                    byte_count_reg <= count_next;
                    odd_reg        <= !odd_reg;
                    if (odd_reg) begin
                        running_sum_reg <= sum_next;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pending_reg <= s_data_byte;
            if (s_last_byte) begin
                seg_reg.sum <= sum_next;
                seg_reg.len <= count_next;
            end
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> seg_valid_reg && !odd_reg && byte_count_reg == '0)
        else $error("segment state not cleared after last byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_valid_reg && !seg_take |-> !s_ready)
        else $error("finished segment could be overwritten");

endmodule

`default_nettype wire

// ----- hdl/tcp_segment_checksum.sv -----
// ----------------------------------------------------------------------------
// tcp_segment_checksum
// TCP checksum over a byte stream with the IPv4 pseudo-header folded in.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock, no gaps between segments, while m_ready
// keeps up; else s_ready stalls. Each result moves from the accumulator's
// segment register to the output register; the two let the next segment
// stream in while a finished checksum waits on m_ready.
// Reset (aresetn low, synchronous) clears the sum, count and valid flags,
// sets both addresses to zero and the protocol number to 6.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_segment_checksum (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tcs_pkg::ADDR_W-1:0]      cfg_wdata,
    // segment bytes in
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tcs_pkg::BYTE_W-1:0]      s_data_byte,
    input  wire logic                            s_last_byte,
    // checksum out
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [tcs_pkg::WORD_W-1:0]           m_checksum,
    output logic [tcs_pkg::WORD_W-1:0]           m_segment_length
);

    logic [tcs_pkg::ADDR_W-1:0]  src_addr_reg;
    logic [tcs_pkg::ADDR_W-1:0]  dst_addr_reg;
    logic [tcs_pkg::PROTO_W-1:0] proto_reg;
    // pseudo-header partial sum, refreshed every cycle from the registers; the
    // user moves config only while idle (not enforced), so folds see it settled
    logic [tcs_pkg::PH_W-1:0]    ph_sum_reg;
    logic [tcs_pkg::PH_W-1:0]    ph_sum_next;

    logic                        m_valid_reg;
    logic [tcs_pkg::WORD_W-1:0]  checksum_reg;
    logic [tcs_pkg::WORD_W-1:0]  length_reg;

    logic                        seg_valid;
    tcs_pkg::seg_t               seg;
    logic                        seg_take;

    logic [tcs_pkg::SUM_W-1:0]   total;
    logic [tcs_pkg::WORD_W:0]    fold1;
    logic [tcs_pkg::WORD_W:0]    fold2;

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            proto_reg    <= tcs_pkg::PROTO_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcs_pkg::CFG_SRC_ADDR: src_addr_reg <= cfg_wdata;
                tcs_pkg::CFG_DST_ADDR: dst_addr_reg <= cfg_wdata;
                tcs_pkg::CFG_PROTO:    proto_reg    <= cfg_wdata[tcs_pkg::PROTO_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign ph_sum_next =
          {{(tcs_pkg::PH_W-tcs_pkg::WORD_W){1'b0}}, src_addr_reg[31:16]}
        + {{(tcs_pkg::PH_W-tcs_pkg::WORD_W){1'b0}}, src_addr_reg[15:0]}
        + {{(tcs_pkg::PH_W-tcs_pkg::WORD_W){1'b0}}, dst_addr_reg[31:16]}
        + {{(tcs_pkg::PH_W-tcs_pkg::WORD_W){1'b0}}, dst_addr_reg[15:0]}
        + {{(tcs_pkg::PH_W-tcs_pkg::PROTO_W){1'b0}}, proto_reg};

    always_ff @(posedge aclk) begin
        ph_sum_reg <= ph_sum_next;
    end

    // ---------------- stage 1: byte pairing and running sum ----------------
    tcs_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .seg_take    (seg_take),
        .seg_valid   (seg_valid),
        .seg         (seg)
    );

    // ---------------- stage 2: pseudo-header, fold, complement ----------------
    // output register frees when empty or when the result is taken
    assign seg_take = seg_valid && (!m_valid_reg || m_ready);

    // sum wraps at 32 bits like the running sum
    assign total = seg.sum
                 + {{(tcs_pkg::SUM_W-tcs_pkg::WORD_W){1'b0}}, seg.len}
                 + {{(tcs_pkg::SUM_W-tcs_pkg::PH_W){1'b0}}, ph_sum_reg};

    // two end-around folds; the second never carries out of 16 bits
    assign fold1 = {1'b0, total[31:16]} + {1'b0, total[15:0]};
    assign fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seg_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seg_take) begin
            checksum_reg <= ~fold2[tcs_pkg::WORD_W-1:0];
            length_reg   <= seg.len;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_checksum       = checksum_reg;
    assign m_segment_length = length_reg;

    a_fold_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_valid |-> !fold2[tcs_pkg::WORD_W])
        else $error("second fold carried out of 16 bits");

    a_take_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_take |=> m_valid_reg && m_segment_length == $past(seg.len))
        else $error("segment not moved into output register");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !seg_valid)
        else $error("valid flags not cleared by reset");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - TCP segment checksum testbench
// Streams TCP segments byte by byte into the block and checks every
// checksum and segment length against an in-bench model of the
// one's-complement sum, under several pseudo-header settings.
// ----------------------------------------------------------------------------

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [tcs_pkg::WORD_W-1:0] checksum;
        logic [tcs_pkg::WORD_W-1:0] length;
    } csum_result_t;

    // Running model of the checksum engine plus the queue of checksums
    // still owed by the block.
    class tcp_csum_predictor;
        logic [tcs_pkg::ADDR_W-1:0]  src_addr;
        logic [tcs_pkg::ADDR_W-1:0]  dst_addr;
        logic [tcs_pkg::PROTO_W-1:0] proto;
        logic [tcs_pkg::SUM_W-1:0]   word_sum;
        logic [tcs_pkg::WORD_W-1:0]  byte_cnt;
        logic [tcs_pkg::BYTE_W-1:0]  high_byte;
        logic                        odd;
        csum_result_t                expected_sums[$];
        int                          mismatches;

        function new();
            src_addr   = '0;
            dst_addr   = '0;
            proto      = tcs_pkg::PROTO_RESET;
            word_sum   = '0;
            byte_cnt   = '0;
            high_byte  = '0;
            odd        = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [tcs_pkg::CFG_IDX_W-1:0] idx,
                                logic [tcs_pkg::ADDR_W-1:0] val);
            case (idx)
                tcs_pkg::CFG_SRC_ADDR: src_addr = val;
                tcs_pkg::CFG_DST_ADDR: dst_addr = val;
                tcs_pkg::CFG_PROTO:    proto    = val[tcs_pkg::PROTO_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted request: a byte of the segment
        function void take_byte(logic [tcs_pkg::BYTE_W-1:0] d, logic is_last);
            logic [tcs_pkg::SUM_W-1:0]  s;
            logic [tcs_pkg::WORD_W-1:0] count;
            csum_result_t               r;
            count = byte_cnt + 16'd1;
            if (!is_last) begin
                if (odd) begin
                    word_sum = word_sum + {16'd0, high_byte, d};
                    high_byte = '0;
                    odd = 1'b0;
                end else begin
                    high_byte = d;
                    odd = 1'b1;
                end
                byte_cnt = count;
                return;
            end
            // closing byte: pad if odd, then add the pseudo-header
            s = word_sum + (odd ? {16'd0, high_byte, d} : {16'd0, d, 8'h00});
            s = s + {16'd0, src_addr[31:16]} + {16'd0, src_addr[15:0]}
                  + {16'd0, dst_addr[31:16]} + {16'd0, dst_addr[15:0]}
                  + {24'd0, proto} + {16'd0, count};
            s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
            s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
            r.checksum = ~s[15:0];
            r.length   = count;
            expected_sums.push_back(r);
            word_sum  = '0;
            byte_cnt  = '0;
            high_byte = '0;
            odd       = 1'b0;
        endfunction

        function void check_sum(logic [tcs_pkg::WORD_W-1:0] csum,
                                logic [tcs_pkg::WORD_W-1:0] len);
            csum_result_t r;
            if (expected_sums.size() == 0) begin
                $error("unexpected result: checksum %h, segment_length %0d", csum, len);
                mismatches++;
                return;
            end
            r = expected_sums.pop_front();
            if (csum !== r.checksum) begin
                $error("checksum: expected %h, got %h", r.checksum, csum);
                mismatches++;
            end
            if (len !== r.length) begin
                $error("segment_length: expected %0d, got %0d", r.length, len);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index = tcs_pkg::CFG_SRC_ADDR;
    logic [tcs_pkg::ADDR_W-1:0]    cfg_wdata = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [tcs_pkg::BYTE_W-1:0]    s_data_byte = '0;
    logic                          s_last_byte = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [tcs_pkg::WORD_W-1:0]    m_checksum;
    logic [tcs_pkg::WORD_W-1:0]    m_segment_length;

    // calm: both sides stop idling; hold_req: ask the sink for one long stall
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    tcp_csum_predictor board = new();

    always #5 aclk = ~aclk;

    tcp_segment_checksum dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_checksum       (m_checksum),
        .m_segment_length (m_segment_length)
    );

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off on request.
    // The hold-off is counted here, independent of the sender, so the
    // sender keeps offering bytes until the pipeline backs up into s_ready.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
            if (hold_left == 0)
                hold_done = 1'b1;
        end else if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_left = 400;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // Every accepted result is compared against the oldest expectation.
    // Values are sampled before this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_sum(m_checksum, m_segment_length);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one byte request; valid stays high with the payload fixed until
    // taken. Valid is only dropped for an idle gap, never in the same step
    // that raises it again.
    task automatic send_byte(input logic [tcs_pkg::BYTE_W-1:0] d, input logic is_last);
        if (!calm) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= is_last;
        do @(posedge aclk); while (!s_ready);
        board.take_byte(d, is_last);
    endtask

    // fill < 0: random bytes, biased toward 0x00 and 0xFF to stress carries
    task automatic send_segment(input int len, input int fill);
        logic [tcs_pkg::BYTE_W-1:0] d;
        for (int i = 0; i < len; i++) begin
            if (fill >= 0)
                d = fill[7:0];
            else
                case ($urandom_range(7))
                    0:       d = 8'h00;
                    1:       d = 8'hff;
                    default: d = 8'($urandom_range(255));
                endcase
            send_byte(d, i == len - 1);
        end
    endtask

    // Random segments, mostly short, now and then a longer one.
    task automatic send_random_traffic(input int n_bytes);
        int sent;
        int seg_len;
        sent = 0;
        while (sent < n_bytes) begin
            seg_len = ($urandom_range(9) == 0) ? $urandom_range(200, 25)
                                               : $urandom_range(24, 1);
            send_segment(seg_len, -1);
            sent += seg_len;
        end
    endtask

    // Every phase ends on a closing byte, so once the queue is empty every
    // result has been taken and both pipeline stages are empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcs_pkg::ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [tcs_pkg::ADDR_W-1:0] src,
                              input logic [tcs_pkg::ADDR_W-1:0] dst,
                              input logic [tcs_pkg::PROTO_W-1:0] proto);
        write_reg(tcs_pkg::CFG_SRC_ADDR, src);
        write_reg(tcs_pkg::CFG_DST_ADDR, dst);
        write_reg(tcs_pkg::CFG_PROTO, {24'd0, proto});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset pseudo-header (addresses zero, protocol 6):
        // one-byte segments at both byte extremes, an even pair, an odd
        // trailer that must be zero-padded, a mixed word and an all-ones run.
        send_segment(1, 8'h00);
        send_segment(1, 8'hff);
        send_segment(2, 8'hff);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_segment(8, 8'hff);
        drain();

        // all-ones pseudo-header
        set_config(32'hffff_ffff, 32'hffff_ffff, 8'hff);
        send_random_traffic(475);
        drain();

        // all-zero pseudo-header; whole phase without idling on either side
        set_config(32'h0, 32'h0, 8'h00);
        calm = 1'b1;
        send_random_traffic(475);
        drain();
        calm = 1'b0;

        // random pseudo-header, with the sink stalled for a long stretch
        set_config($urandom, $urandom, 8'($urandom_range(255)));
        hold_req = 1'b1;
        send_random_traffic(475);
        drain();

        // typical addresses, TCP protocol number
        set_config(32'hc0a8_0001, 32'h0a00_0002, 8'd6);
        send_random_traffic(475);
        drain();

        repeat (8) @(posedge aclk);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
